@@ rtl/touch_swipe_gesture_detector_defines.svh @@
// Assertion macros for the top RTL file of the swipe detector.
`ifndef TOUCH_SWIPE_GESTURE_DETECTOR_DEFINES_SVH
`define TOUCH_SWIPE_GESTURE_DETECTOR_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define TSGD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define TSGD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/tsgd_pkg.sv @@
`default_nettype none
package tsgd_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Field widths fixed by the interface.
	localparam int COUNT_W   = 4;
	localparam int RAW_W     = 13;
	localparam int PANEL_W   = 10;
	localparam int SAMPLES_W = 8;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TRAVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES  = 3'd4;

	// Register reset values.
	localparam logic [PANEL_W-1:0]   PANEL_WIDTH_RST  = 10'd466;
	localparam logic [PANEL_W-1:0]   PANEL_HEIGHT_RST = 10'd466;
	localparam logic [PANEL_W-1:0]   MIN_TRAVEL_RST   = 10'd40;
	localparam logic [SAMPLES_W-1:0] MIN_SAMPLES_RST  = 8'd3;

	localparam logic [SAMPLES_W-1:0] PRESS_COUNT_MAX = 8'd255;

	// Gesture codes reported on the result.
	typedef enum logic [2:0] {
		GEST_NONE  = 3'd0,
		GEST_LEFT  = 3'd1,
		GEST_RIGHT = 3'd2,
		GEST_UP    = 3'd3,
		GEST_DOWN  = 3'd4
	} gesture_t;

endpackage
`default_nettype wire

@@ rtl/tsgd_classify.sv @@
`default_nettype none
module tsgd_classify #(
	parameter int COORD_BITS = 10
) (
	input  wire logic [COORD_BITS-1:0]          start_x,
	input  wire logic [COORD_BITS-1:0]          start_y,
	input  wire logic [COORD_BITS-1:0]          last_x,
	input  wire logic [COORD_BITS-1:0]          last_y,
	input  wire logic [tsgd_pkg::PANEL_W-1:0]   min_travel,
	output tsgd_pkg::gesture_t                  gesture
);
	import tsgd_pkg::*;

	// Compare width covers the doubled travel and the threshold.
	localparam int CMP_W = ((COORD_BITS > PANEL_W) ? COORD_BITS : PANEL_W) + 2;

	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic [COORD_BITS-1:0]      adx;
	logic [COORD_BITS-1:0]      ady;
	logic [CMP_W-1:0]           adx_e;
	logic [CMP_W-1:0]           ady_e;
	logic [CMP_W-1:0]           adx2_e;
	logic [CMP_W-1:0]           ady2_e;
	logic [CMP_W-1:0]           travel_e;

	// Signed travel and its magnitude on each axis.
	always_comb begin
		dx       = $signed({1'b0, last_x}) - $signed({1'b0, start_x});
		dy       = $signed({1'b0, last_y}) - $signed({1'b0, start_y});
		adx      = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
		ady      = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
		adx_e    = CMP_W'(adx);
		ady_e    = CMP_W'(ady);
		adx2_e   = CMP_W'({adx, 1'b0});
		ady2_e   = CMP_W'({ady, 1'b0});
		travel_e = CMP_W'(min_travel);
	end

	// The horizontal test wins when both axes qualify.
	always_comb begin
		gesture = GEST_NONE;
		if (adx_e >= travel_e && adx_e >= ady2_e) begin
			gesture = dx[COORD_BITS] ? GEST_LEFT : GEST_RIGHT;
		end else if (ady_e >= travel_e && ady_e >= adx2_e) begin
			gesture = dy[COORD_BITS] ? GEST_UP : GEST_DOWN;
		end
	end

endmodule
`default_nettype wire

@@ rtl/touch_swipe_gesture_detector.sv @@
// Touch swipe gesture detector.
// The sample channel (sample_valid, sample_stall) carries one touch poll per
// beat: point_count, raw_x and raw_y. The result channel (result_valid,
// result_stall) returns exactly one beat per poll, in order: pressed,
// point_x, point_y and gesture. A swipe is reported on the result of the
// poll that releases the press.
// A taken sample beat waits in the input register; once the output register
// is free or draining, the classification and state update land in the
// output register, which drives result_valid.
// Throughput is one poll per cycle while the receiver does not stall, set by
// the single pass through the bounds check, rotation and swipe compare.
// When the receiver stalls, the output register holds its beat and one more
// sample is still taken into the input register; after that sample_stall
// rises until the result moves.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no poll is in flight.
// Reset (arst_n low) empties both registers, clears the press tracking and
// loads the register defaults: 466 by 466 panel, no rotation, 40 pixels of
// travel and 3 samples.
`default_nettype none
`include "touch_swipe_gesture_detector_defines.svh"
module touch_swipe_gesture_detector #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Sample channel.
	input  wire logic                            sample_valid,
	output logic                                 sample_stall,
	input  wire logic [tsgd_pkg::COUNT_W-1:0]    point_count,
	input  wire logic signed [tsgd_pkg::RAW_W-1:0] raw_x,
	input  wire logic signed [tsgd_pkg::RAW_W-1:0] raw_y,
	// Result channel.
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic                                 pressed,
	output logic [COORD_BITS-1:0]                point_x,
	output logic [COORD_BITS-1:0]                point_y,
	output logic [2:0]                           gesture,
	// Configuration channel.
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tsgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tsgd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsgd_pkg::*;

	// Configuration registers.
	logic [PANEL_W-1:0]   panel_width_q;
	logic [PANEL_W-1:0]   panel_height_q;
	logic                 rotate_q;
	logic [PANEL_W-1:0]   min_travel_q;
	logic [SAMPLES_W-1:0] min_samples_q;

	// Input stage.
	logic                     valid_s1;
	logic [COUNT_W-1:0]       count_s1;
	logic signed [RAW_W-1:0]  raw_x_s1;
	logic signed [RAW_W-1:0]  raw_y_s1;

	// Output stage.
	logic                  valid_s2;
	logic                  pressed_s2;
	logic [COORD_BITS-1:0] point_x_s2;
	logic [COORD_BITS-1:0] point_y_s2;
	gesture_t              gesture_s2;

	// Press tracking state.
	logic                  was_pressed_q;
	logic [COORD_BITS-1:0] start_x_q;
	logic [COORD_BITS-1:0] start_y_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;
	logic [SAMPLES_W-1:0]  press_count_q;
	logic [COORD_BITS-1:0] held_x_q;
	logic [COORD_BITS-1:0] held_y_q;

	// Handshake control.
	logic sample_fire;
	logic advance;

	// Per-poll combinational results.
	logic                  touched;
	logic [PANEL_W-1:0]    px_full;
	logic [PANEL_W-1:0]    py_full;
	logic [COORD_BITS-1:0] px;
	logic [COORD_BITS-1:0] py;
	logic                  swipe_ok;
	gesture_t              swipe_code;
	gesture_t              gesture_next;
	logic [SAMPLES_W-1:0]  press_count_next;

	assign cfg_ready = 1'b1;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= PANEL_WIDTH_RST;
			panel_height_q <= PANEL_HEIGHT_RST;
			rotate_q       <= 1'b0;
			min_travel_q   <= MIN_TRAVEL_RST;
			min_samples_q  <= MIN_SAMPLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PANEL_WIDTH:  panel_width_q  <= cfg_data;
				REG_PANEL_HEIGHT: panel_height_q <= cfg_data;
				REG_ROTATE:       rotate_q       <= cfg_data[0];
				REG_MIN_TRAVEL:   min_travel_q   <= cfg_data;
				REG_MIN_SAMPLES:  min_samples_q  <= cfg_data[SAMPLES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The input stage moves on when the output register is free or draining.
	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !advance;
	assign sample_fire  = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_fire) begin
			count_s1 <= point_count;
			raw_x_s1 <= raw_x;
			raw_y_s1 <= raw_y;
		end
	end

	// Bounds check and optional quarter turn.
	always_comb begin
		touched = (count_s1 != '0) && !raw_x_s1[RAW_W-1] && !raw_y_s1[RAW_W-1]
			&& (raw_x_s1[RAW_W-2:0] < (RAW_W-1)'(panel_width_q))
			&& (raw_y_s1[RAW_W-2:0] < (RAW_W-1)'(panel_height_q));
		if (rotate_q) begin
			px_full = raw_y_s1[PANEL_W-1:0];
			py_full = panel_width_q - PANEL_W'(1) - raw_x_s1[PANEL_W-1:0];
		end else begin
			px_full = raw_x_s1[PANEL_W-1:0];
			py_full = raw_y_s1[PANEL_W-1:0];
		end
		px = COORD_BITS'(px_full);
		py = COORD_BITS'(py_full);
	end

	tsgd_classify #(
		.COORD_BITS (COORD_BITS)
	) u_classify (
		.start_x    (start_x_q),
		.start_y    (start_y_q),
		.last_x     (last_x_q),
		.last_y     (last_y_q),
		.min_travel (min_travel_q),
		.gesture    (swipe_code)
	);

	// A release of a long enough press reports the classified swipe.
	always_comb begin
		swipe_ok     = !touched && was_pressed_q && (press_count_q >= min_samples_q);
		gesture_next = swipe_ok ? swipe_code : GEST_NONE;
		if (!was_pressed_q) begin
			press_count_next = SAMPLES_W'(1);
		end else if (press_count_q == PRESS_COUNT_MAX) begin
			press_count_next = PRESS_COUNT_MAX;
		end else begin
			press_count_next = press_count_q + SAMPLES_W'(1);
		end
	end

	// Press tracking advances with each poll that reaches the output stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			press_count_q <= '0;
			held_x_q      <= '0;
			held_y_q      <= '0;
		end else if (advance) begin
			was_pressed_q <= touched;
			if (touched) begin
				if (!was_pressed_q) begin
					start_x_q <= px;
					start_y_q <= py;
				end
				last_x_q      <= px;
				last_y_q      <= py;
				press_count_q <= press_count_next;
				held_x_q      <= px;
				held_y_q      <= py;
			end else begin
				press_count_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pressed_s2 <= touched;
			point_x_s2 <= touched ? px : held_x_q;
			point_y_s2 <= touched ? py : held_y_q;
			gesture_s2 <= gesture_next;
		end
	end

	assign result_valid = valid_s2;
	assign pressed      = pressed_s2;
	assign point_x      = point_x_s2;
	assign point_y      = point_y_s2;
	assign gesture      = gesture_s2;

	// A gesture only rides on a released sample.
	`TSGD_ASSERT_IMPLY(a_gesture_on_release, clk, arst_n,
		valid_s2 && (gesture_s2 != GEST_NONE), !pressed_s2)
	// An ongoing press has counted at least one sample.
	`TSGD_ASSERT_IMPLY(a_press_counted, clk, arst_n, was_pressed_q, press_count_q != '0)
	// Stall is raised only while the input stage holds a poll.
	`TSGD_ASSERT_IMPLY(a_stall_needs_item, clk, arst_n, sample_stall, valid_s1)
	// A touched poll leaves the press tracker in the pressed state.
	`TSGD_ASSERT_NEXT(a_press_tracked, clk, arst_n, advance && touched, was_pressed_q)

endmodule
`default_nettype wire

@@ bench/tb_touch_swipe_gesture_detector.sv @@
`timescale 1ns / 100ps
module tb_touch_swipe_gesture_detector;
	import tsgd_pkg::*;

	localparam int IDLE_PCT       = 12;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int AXIS_RATIO     = 2;
	localparam int SATURATE_LEN   = 260;

	// One result beat as the block reports it.
	typedef struct packed {
		logic               pressed;
		logic [PANEL_W-1:0] x;
		logic [PANEL_W-1:0] y;
		gesture_t           gesture;
	} report_t;

	// One row of the directed stimulus; typed rows carry their own answer.
	typedef struct {
		logic [COUNT_W-1:0] cnt;
		int                 x;
		int                 y;
		bit                 typed;
		report_t            rpt;
	} poll_row_t;

	localparam report_t RELEASED_RST = '{1'b0, 10'd0, 10'd0, GEST_NONE};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic [COUNT_W-1:0]    point_count = '0;
	logic signed [RAW_W-1:0] raw_x = '0;
	logic signed [RAW_W-1:0] raw_y = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  pressed;
	logic [PANEL_W-1:0]    point_x;
	logic [PANEL_W-1:0]    point_y;
	logic [2:0]            gesture;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow of the configuration registers.
	logic [PANEL_W-1:0]   cfg_width = PANEL_WIDTH_RST;
	logic [PANEL_W-1:0]   cfg_height = PANEL_HEIGHT_RST;
	logic                 cfg_rotate = 1'b0;
	logic [PANEL_W-1:0]   cfg_min_travel = MIN_TRAVEL_RST;
	logic [SAMPLES_W-1:0] cfg_min_samples = MIN_SAMPLES_RST;

	// Press tracking, as the block should hold it.
	bit                   in_press = 1'b0;
	logic [PANEL_W-1:0]   first_x = '0, first_y = '0;
	logic [PANEL_W-1:0]   latest_x = '0, latest_y = '0;
	logic [SAMPLES_W-1:0] press_len = '0;
	logic [PANEL_W-1:0]   held_x = '0, held_y = '0;

	report_t touch_reports [$];
	int      failures = 0;
	int      polls_sent = 0;
	int      quiet_cycles = 0;
	bit      gaps_on = 1'b1;

	// Directed polls under the reset configuration (466 by 466, 40 pixels, 3 samples).
	poll_row_t poll_table [25] = '{
		'{4'd0,     0,     0, 1'b1, RELEASED_RST},
		'{4'd1, -4096,     5, 1'b1, RELEASED_RST},
		'{4'd15,    5,    -1, 1'b1, RELEASED_RST},
		'{4'd1,   466,    10, 1'b1, RELEASED_RST},
		'{4'd1,    10,   466, 1'b1, RELEASED_RST},
		'{4'd1,  4095,  4095, 1'b1, RELEASED_RST},
		'{4'd1,   465,   465, 1'b1, '{1'b1, 10'd465, 10'd465, GEST_NONE}},
		'{4'd1,     0,     0, 1'b1, '{1'b1, 10'd0, 10'd0, GEST_NONE}},
		'{4'd0,     0,     0, 1'b0, '0},
		// Right swipe of exactly the minimum travel at the axis ratio.
		'{4'd1,   100,   200, 1'b0, '0},
		'{4'd1,   120,   210, 1'b0, '0},
		'{4'd2,   140,   220, 1'b0, '0},
		'{4'd0,   140,   220, 1'b0, '0},
		'{4'd3,   300,    50, 1'b0, '0},
		'{4'd3,   250,    60, 1'b0, '0},
		'{4'd3,   200,    70, 1'b0, '0},
		'{4'd1,    -1,    -1, 1'b0, '0},
		'{4'd1,    50,   400, 1'b0, '0},
		'{4'd1,    55,   300, 1'b0, '0},
		'{4'd1,    60,   100, 1'b0, '0},
		'{4'd0,    60,   100, 1'b0, '0},
		'{4'd4,   400,    10, 1'b0, '0},
		'{4'd4,   400,   200, 1'b0, '0},
		'{4'd4,   410,   465, 1'b0, '0},
		'{4'd1,   466,   466, 1'b0, '0}
	};

	touch_swipe_gesture_detector DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the report for one poll and advances the press tracking.
	function automatic report_t predict_touch_report(input logic [COUNT_W-1:0] cnt,
			input logic signed [RAW_W-1:0] rx, input logic signed [RAW_W-1:0] ry);
		report_t            r;
		int                 ix, iy, dx, dy, adx, ady;
		logic [PANEL_W-1:0] px, py;
		bit                 touch;
		ix = rx;
		iy = ry;
		touch = cnt != 0 && ix >= 0 && iy >= 0 &&
			ix < int'(cfg_width) && iy < int'(cfg_height);
		r.gesture = GEST_NONE;
		if (touch) begin
			if (cfg_rotate) begin
				px = iy[PANEL_W-1:0];
				py = cfg_width - 10'd1 - ix[PANEL_W-1:0];
			end else begin
				px = ix[PANEL_W-1:0];
				py = iy[PANEL_W-1:0];
			end
			if (!in_press) begin
				first_x = px;
				first_y = py;
				press_len = '0;
			end
			latest_x = px;
			latest_y = py;
			if (press_len != PRESS_COUNT_MAX)
				press_len++;
			held_x = px;
			held_y = py;
		end else begin
			// A release of a long enough press classifies the travel.
			if (in_press && press_len >= cfg_min_samples) begin
				dx = int'(latest_x) - int'(first_x);
				dy = int'(latest_y) - int'(first_y);
				adx = dx < 0 ? -dx : dx;
				ady = dy < 0 ? -dy : dy;
				if (adx >= int'(cfg_min_travel) && adx >= ady * AXIS_RATIO)
					r.gesture = dx < 0 ? GEST_LEFT : GEST_RIGHT;
				else if (ady >= int'(cfg_min_travel) && ady >= adx * AXIS_RATIO)
					r.gesture = dy < 0 ? GEST_UP : GEST_DOWN;
			end
			press_len = '0;
		end
		in_press = touch;
		r.pressed = touch;
		r.x = held_x;
		r.y = held_y;
		return r;
	endfunction

	// Drives one poll beat, holds it until taken, and queues its report.
	task automatic send_poll(input logic [COUNT_W-1:0] cnt, input int x, input int y,
			input bit typed, input report_t typed_rpt);
		report_t predicted;
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		point_count <= cnt;
		raw_x <= x[RAW_W-1:0];
		raw_y <= y[RAW_W-1:0];
		do @(posedge clk); while (sample_stall);
		predicted = predict_touch_report(cnt, x[RAW_W-1:0], y[RAW_W-1:0]);
		touch_reports.push_back(typed ? typed_rpt : predicted);
		polls_sent++;
	endtask

	// Stops the sample channel and waits until every report is back.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (touch_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PANEL_WIDTH:  cfg_width = data;
			REG_PANEL_HEIGHT: cfg_height = data;
			REG_ROTATE:       cfg_rotate = data[0];
			REG_MIN_TRAVEL:   cfg_min_travel = data;
			REG_MIN_SAMPLES:  cfg_min_samples = data[SAMPLES_W-1:0];
			default: ;
		endcase
	endtask

	// Rewrites every register once the block has gone quiet.
	task automatic write_all(input int w, input int h, input int rot, input int trav,
			input int samp);
		wait_idle();
		write_reg(REG_PANEL_WIDTH, w[CFG_DATA_W-1:0]);
		write_reg(REG_PANEL_HEIGHT, h[CFG_DATA_W-1:0]);
		write_reg(REG_ROTATE, rot[CFG_DATA_W-1:0]);
		write_reg(REG_MIN_TRAVEL, trav[CFG_DATA_W-1:0]);
		write_reg(REG_MIN_SAMPLES, samp[CFG_DATA_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// A press that travels in a line across the panel, then one releasing poll.
	task automatic send_swipe();
		int n, sx, sy, ex, ey, steps, i, w, h;
		w = int'(cfg_width);
		h = int'(cfg_height);
		n = $urandom_range(1, 8);
		steps = n > 1 ? n - 1 : 1;
		sx = $urandom_range(0, w - 1);
		sy = $urandom_range(0, h - 1);
		ex = $urandom_range(0, w - 1);
		ey = $urandom_range(0, h - 1);
		// Mostly keep one axis short so that swipes are common.
		case ($urandom_range(0, 2))
			0: ey = sy + (ey - sy) / int'($urandom_range(2, 6));
			1: ex = sx + (ex - sx) / int'($urandom_range(2, 6));
			default: ;
		endcase
		for (i = 0; i < n; i++)
			send_poll(COUNT_W'($urandom_range(1, 15)), sx + (ex - sx) * i / steps,
				sy + (ey - sy) * i / steps, 1'b0, '0);
		case ($urandom_range(0, 3))
			0: send_poll(4'd0, $urandom_range(0, 8191), $urandom_range(0, 8191), 1'b0, '0);
			1: send_poll(COUNT_W'($urandom_range(1, 15)), -int'($urandom_range(1, 4096)), ey,
				1'b0, '0);
			2: send_poll(COUNT_W'($urandom_range(1, 15)), $urandom_range(w, 4095), ey,
				1'b0, '0);
			default: send_poll(COUNT_W'($urandom_range(1, 15)), ex, $urandom_range(h, 4095),
				1'b0, '0);
		endcase
	endtask

	task automatic run_phase(input int w, input int h, input int rot, input int trav,
			input int samp, input int items);
		int start;
		write_all(w, h, rot, trav, samp);
		start = polls_sent;
		while (polls_sent - start < items) begin
			if (cfg_width == 0 || cfg_height == 0 || $urandom_range(99) < 15)
				send_poll(COUNT_W'($urandom_range(0, 15)), $urandom_range(0, 8191),
					$urandom_range(0, 8191), 1'b0, '0);
			else
				send_swipe();
		end
	endtask

	// The receiver stalls at random while gaps are enabled.
	always @(posedge clk)
		result_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);

	// Result checking and the count of cycles with no beat on any channel.
	always @(posedge clk) begin
		report_t got, want;
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (result_valid && !result_stall) begin
				got = '{pressed, point_x, point_y, gesture_t'(gesture)};
				if (touch_reports.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result beat with no poll pending: pressed=%0d x=%0d y=%0d g=%0d",
							$time, got.pressed, got.x, got.y, got.gesture);
				end else begin
					want = touch_reports.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= 10)
							$display({"%0t: report mismatch: expected pressed=%0d x=%0d y=%0d g=%0d,",
								" got pressed=%0d x=%0d y=%0d g=%0d"}, $time,
								want.pressed, want.x, want.y, want.gesture,
								got.pressed, got.x, got.y, got.gesture);
					end
				end
			end
		end
	end

	// Ends the run if the channels stop moving.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (poll_table[k])
			send_poll(poll_table[k].cnt, poll_table[k].x, poll_table[k].y,
				poll_table[k].typed, poll_table[k].rpt);

		// Largest panel with rotation and no idling on either side.
		gaps_on = 1'b0;
		run_phase(1023, 1023, 1, 0, 1, 65);
		gaps_on = 1'b1;
		run_phase(1, 1, 0, 1023, 0, 40);
		run_phase($urandom_range(64, 1023), $urandom_range(64, 1023), 1,
			$urandom_range(0, 100), $urandom_range(1, 6), 65);
		// Zero-sized panels turn every poll into a release.
		run_phase(0, 500, 0, 40, 3, 30);
		run_phase(400, 0, 1, 40, 3, 30);
		repeat (2)
			run_phase($urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(0, 1),
				$urandom_range(0, 150), $urandom_range(0, 6), 65);

		// One very long press drives the sample count into saturation.
		write_all(466, 466, 0, 40, 255);
		for (i = 0; i < SATURATE_LEN; i++)
			send_poll(4'd1, 20 + i * 380 / (SATURATE_LEN - 1),
				100 + i * 10 / (SATURATE_LEN - 1), 1'b0, '0);
		send_poll(4'd0, 0, 0, 1'b0, '0);
		run_phase(466, 466, 0, 40, 3, 40);

		wait_idle();
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsgd_pkg.sv
rtl/tsgd_classify.sv
rtl/touch_swipe_gesture_detector.sv
bench/tb_touch_swipe_gesture_detector.sv
